// ===== rtl/bcm_pkg.sv =====
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types and constants of the battery charge monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [SampleW-1:0] ChargeHighRst = 8'hFF;

  typedef enum logic [1:0] {
    CMD_VOLTAGE = 2'd0,
    CMD_TEMP    = 2'd1,
    CMD_CHARGER = 2'd2,
    CMD_USB_PIN = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_POWER_OFF    = 3'd1,
    EV_LOW_BATT     = 3'd2,
    EV_STOP_AND_OFF = 3'd3,
    EV_CHG_STARTED  = 3'd4,
    EV_FULL         = 3'd5,
    EV_CHG_STOPPED  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_NOT_CHARGING = 2'd0,
    ST_CHARGING     = 2'd1,
    ST_UNKNOWN      = 2'd2
  } chg_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_LOW_CHG  = 3'd0,
    CFG_TEMP_LOW_DIS  = 3'd1,
    CFG_VOLT_CUTOFF   = 3'd2,
    CFG_VOLT_LOW      = 3'd3,
    CFG_CHARGE_LOW    = 3'd4,
    CFG_CHARGE_HIGH   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] temp_low_charging;
    logic [SampleW-1:0] temp_low_discharging;
    logic [SampleW-1:0] volt_cutoff;
    logic [SampleW-1:0] volt_low;
    logic [SampleW-1:0] charge_level_low;
    logic [SampleW-1:0] charge_level_high;
  } cfg_t;

  // Monitor state carried between requests
  typedef struct packed {
    chg_state_e chg_state;
    logic       ext_power;
  } mon_state_t;

endpackage

`default_nettype wire

// ===== rtl/bcm_req_if.sv =====
// ----------------------------------------------------------------------------
// bcm_req_if
// Request channel: one tagged sample with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] sample;
  logic       pin_level;

  modport source (output valid, command, sample, pin_level, input ready);
  modport sink   (input valid, command, sample, pin_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcm_res_if.sv =====
// ----------------------------------------------------------------------------
// bcm_res_if
// Result channel: event code and charging state with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcm_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] charge_state;

  modport source (output valid, event_res, charge_state, input ready);
  modport sink   (input valid, event_res, charge_state, output ready);
endinterface

`default_nettype wire

// ===== rtl/battery_charge_monitor.sv =====
// ----------------------------------------------------------------------------
// battery_charge_monitor
// Battery voltage/temperature/charger supervision with event reporting.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per handshake: a command tag (voltage,
//   temperature, charger status, usb detect pin), an 8-bit sample and the
//   pin level. res_o returns exactly one result per request: an event code
//   and the charging state after that request, in request order.
//   Thresholds are written through cfg_we_i/cfg_idx_i/cfg_data_i while no
//   request is in flight; indexes above the last register are dropped.
// Timing:
//   Two-stage path: request register, then evaluation logic, then result
//   register, which drives res_o.valid; a request leaves the request register
//   once the result slot is free. One request per cycle is sustained while
//   res_o is ready; the monitor state updates as a request moves into the
//   result register, so back-to-back requests see it.
// Reset:
//   Both stages empty, charging state unknown, no external power,
//   thresholds zero except charge-complete level at 0xFF.
// Backpressure:
//   A stalled result holds in the result register; an empty request register
//   still takes one more request, then req_i.ready drops until res_o moves.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_monitor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bcm_req_if.sink                            req_i,
  bcm_res_if.source                          res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bcm_pkg::SampleW-1:0]   cfg_data_i
);

  bcm_pkg::cfg_t cfg;

  bcm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Request register
  logic                        in_vld_q, in_vld_d;
  logic [1:0]                  cmd_q;
  logic [bcm_pkg::SampleW-1:0] sample_q;
  logic                        pin_q;

  // Result register
  logic                        out_vld_q, out_vld_d;
  bcm_pkg::event_e             ev_q;
  bcm_pkg::chg_state_e         chg_q;

  // Monitor state
  bcm_pkg::mon_state_t         st_q, st_d;

  bcm_pkg::event_e             ev_nxt;
  bcm_pkg::mon_state_t         st_nxt;

  logic                        req_acc;
  logic                        adv;

  // Result slot frees when empty or drained this cycle
  assign adv     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = !in_vld_q || adv;

  bcm_eval u_eval (
    .cfg_i       (cfg),
    .state_i     (st_q),
    .command_i   (cmd_q),
    .sample_i    (sample_q),
    .pin_level_i (pin_q),
    .event_o     (ev_nxt),
    .state_o     (st_nxt)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  assign st_d = adv ? st_nxt : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      st_q.chg_state  <= bcm_pkg::ST_UNKNOWN;
      st_q.ext_power  <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q    <= req_i.command;
      sample_q <= req_i.sample;
      pin_q    <= req_i.pin_level;
    end
    if (adv) begin
      ev_q  <= ev_nxt;
      chg_q <= st_nxt.chg_state;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.event_res    = ev_q;
  assign res_o.charge_state = chg_q;

endmodule

`default_nettype wire

// ===== rtl/bcm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcm_cfg_regs
// Threshold register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bcm_pkg::SampleW-1:0]   cfg_data_i,
  output bcm_pkg::cfg_t                      cfg_o
);

  bcm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bcm_pkg::cfg_idx_e'(cfg_idx_i))
        bcm_pkg::CFG_TEMP_LOW_CHG: cfg_d.temp_low_charging    = cfg_data_i;
        bcm_pkg::CFG_TEMP_LOW_DIS: cfg_d.temp_low_discharging = cfg_data_i;
        bcm_pkg::CFG_VOLT_CUTOFF:  cfg_d.volt_cutoff          = cfg_data_i;
        bcm_pkg::CFG_VOLT_LOW:     cfg_d.volt_low             = cfg_data_i;
        bcm_pkg::CFG_CHARGE_LOW:   cfg_d.charge_level_low     = cfg_data_i;
        bcm_pkg::CFG_CHARGE_HIGH:  cfg_d.charge_level_high    = cfg_data_i;
        default:                   cfg_d = cfg_q; // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_low_charging    <= '0;
      cfg_q.temp_low_discharging <= '0;
      cfg_q.volt_cutoff          <= '0;
      cfg_q.volt_low             <= '0;
      cfg_q.charge_level_low     <= '0;
      cfg_q.charge_level_high    <= bcm_pkg::ChargeHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bcm_eval.sv =====
// ----------------------------------------------------------------------------
// bcm_eval
// Event decision and next monitor state for one request (combinational).
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_eval (
  input  bcm_pkg::cfg_t                    cfg_i,
  input  bcm_pkg::mon_state_t              state_i,
  input  wire logic [1:0]                  command_i,
  input  wire logic [bcm_pkg::SampleW-1:0] sample_i,
  input  wire logic                        pin_level_i,
  output bcm_pkg::event_e                  event_o,
  output bcm_pkg::mon_state_t              state_o
);

  logic [bcm_pkg::SampleW-1:0] temp_lim;
  logic                        charging;

  assign charging = (state_i.chg_state == bcm_pkg::ST_CHARGING);
  assign temp_lim = charging ? cfg_i.temp_low_charging : cfg_i.temp_low_discharging;

  always_comb begin
    event_o = bcm_pkg::EV_NONE;
    state_o = state_i;
    case (bcm_pkg::cmd_e'(command_i))
      bcm_pkg::CMD_VOLTAGE: begin
        if (!state_i.ext_power) begin
          if (sample_i < cfg_i.volt_cutoff) begin
            event_o = bcm_pkg::EV_POWER_OFF;
          end else if (sample_i < cfg_i.volt_low) begin
            event_o = bcm_pkg::EV_LOW_BATT;
          end
        end
      end
      bcm_pkg::CMD_TEMP: begin
        if (sample_i < temp_lim) begin
          event_o = bcm_pkg::EV_STOP_AND_OFF;
        end
      end
      bcm_pkg::CMD_CHARGER: begin
        // low-level test wins when the two levels overlap
        if (sample_i <= cfg_i.charge_level_low) begin
          if (state_i.ext_power) begin
            if (!charging) begin
              event_o = bcm_pkg::EV_CHG_STARTED;
            end
            state_o.chg_state = bcm_pkg::ST_CHARGING;
          end
        end else if (sample_i >= cfg_i.charge_level_high) begin
          if (state_i.ext_power) begin
            if (state_i.chg_state != bcm_pkg::ST_NOT_CHARGING) begin
              event_o = bcm_pkg::EV_FULL;
            end
          end else if (charging) begin
            event_o = bcm_pkg::EV_CHG_STOPPED;
          end
          state_o.chg_state = bcm_pkg::ST_NOT_CHARGING;
        end else begin
          if (charging) begin
            event_o = bcm_pkg::EV_CHG_STOPPED;
          end
          state_o.chg_state = bcm_pkg::ST_NOT_CHARGING;
        end
      end
      bcm_pkg::CMD_USB_PIN: begin
        // sticky until reset
        if (pin_level_i) begin
          state_o.ext_power = 1'b1;
        end
      end
      default: begin
        event_o = bcm_pkg::EV_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/bcm_event_checker.sv =====
// ----------------------------------------------------------------------------
// bcm_event_checker
// Passive scoreboard for the battery charge monitor: it tracks thresholds
// and monitor state, predicts one event per accepted request and compares it
// with the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_event_checker
  import bcm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 req_valid_i,
  input  wire logic                 req_ready_i,
  input  wire logic [1:0]           req_command_i,
  input  wire logic [SampleW-1:0]   req_sample_i,
  input  wire logic                 req_pin_i,
  // result channel
  input  wire logic                 res_valid_i,
  input  wire logic                 res_ready_i,
  input  wire logic [2:0]           res_event_i,
  input  wire logic [1:0]           res_state_i,
  // threshold writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [SampleW-1:0]   cfg_data_i,
  output int unsigned               fail_cnt_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    event_e     ev;
    chg_state_e st;
  } mon_result_t;

  cfg_t        thr;
  chg_state_e  chg;
  logic        ext_pwr;
  mon_result_t pending_events[$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: bcm mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // Applies one request to the tracked state and returns the expected result
  function automatic mon_result_t predict_event(input cmd_e cmd, input logic [SampleW-1:0] s,
                                                input logic pin);
    event_e       ev;
    logic [7:0]   lim;
    mon_result_t  r;
    ev = EV_NONE;
    case (cmd)
      CMD_VOLTAGE: begin
        if (!ext_pwr) begin
          if (s < thr.volt_cutoff) ev = EV_POWER_OFF;
          else if (s < thr.volt_low) ev = EV_LOW_BATT;
        end
      end
      CMD_TEMP: begin
        // unknown counts as not charging
        lim = (chg == ST_CHARGING) ? thr.temp_low_charging : thr.temp_low_discharging;
        if (s < lim) ev = EV_STOP_AND_OFF;
      end
      CMD_CHARGER: begin
        if (s <= thr.charge_level_low) begin
          if (ext_pwr) begin
            if (chg != ST_CHARGING) ev = EV_CHG_STARTED;
            chg = ST_CHARGING;
          end
        end else if (s >= thr.charge_level_high) begin
          if (ext_pwr) begin
            if (chg != ST_NOT_CHARGING) ev = EV_FULL;
          end else if (chg == ST_CHARGING) begin
            ev = EV_CHG_STOPPED;
          end
          chg = ST_NOT_CHARGING;
        end else begin
          if (chg == ST_CHARGING) ev = EV_CHG_STOPPED;
          chg = ST_NOT_CHARGING;
        end
      end
      default: begin
        if (pin) ext_pwr = 1'b1;
      end
    endcase
    r.ev = ev;
    r.st = chg;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mon_result_t want;
    if (!rst_ni) begin
      thr.temp_low_charging    = '0;
      thr.temp_low_discharging = '0;
      thr.volt_cutoff          = '0;
      thr.volt_low             = '0;
      thr.charge_level_low     = '0;
      thr.charge_level_high    = ChargeHighRst;
      chg                      = ST_UNKNOWN;
      ext_pwr                  = 1'b0;
      pending_events.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("result ev=%0d st=%0d with no request waiting",
                                    res_event_i, res_state_i));
        end else begin
          want = pending_events.pop_front();
          if (res_event_i !== want.ev)
            report_mismatch($sformatf("event got %0d want %0d", res_event_i, want.ev));
          if (res_state_i !== want.st)
            report_mismatch($sformatf("charge_state got %0d want %0d", res_state_i, want.st));
        end
      end
      if (req_valid_i && req_ready_i)
        pending_events.push_back(predict_event(cmd_e'(req_command_i), req_sample_i, req_pin_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TEMP_LOW_CHG: thr.temp_low_charging    = cfg_data_i;
          CFG_TEMP_LOW_DIS: thr.temp_low_discharging = cfg_data_i;
          CFG_VOLT_CUTOFF:  thr.volt_cutoff          = cfg_data_i;
          CFG_VOLT_LOW:     thr.volt_low             = cfg_data_i;
          CFG_CHARGE_LOW:   thr.charge_level_low     = cfg_data_i;
          CFG_CHARGE_HIGH:  thr.charge_level_high    = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = pending_events.size();
  end

endmodule

`default_nettype wire

// ===== sim/battery_charge_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// battery_charge_monitor_tb
// Drives tagged samples and threshold settings into the battery charge
// monitor with random request gaps and result backpressure; a scoreboard
// predicts every event and reports the failure count for the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcm_pkg::*;

  // Indexes past the last register; the block must drop these writes
  localparam logic [CfgIdxW-1:0] CfgSpareIdxA = CfgIdxW'(CFG_CHARGE_HIGH + 1);
  localparam logic [CfgIdxW-1:0] CfgSpareIdxB = CfgIdxW'(CFG_CHARGE_HIGH + 2);

  // Limit on the whole run, well above the slowest legal run
  localparam int unsigned RunLimitNs = 2_500_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  bcm_req_if req_if ();
  bcm_res_if res_if ();

  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [SampleW-1:0] cfg_data;

  int unsigned n_fail;
  int unsigned n_pending;

  // Idle rates (percent per item / per cycle), changed in stretches
  int unsigned send_gap_pct;
  int unsigned sink_stall_pct;

  // Last written thresholds; only used to aim samples at the edges
  cfg_t cfg_shadow;

  battery_charge_monitor u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bcm_event_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_command_i (req_if.command),
    .req_sample_i  (req_if.sample),
    .req_pin_i     (req_if.pin_level),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_event_i   (res_if.event_res),
    .res_state_i   (res_if.charge_state),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (n_fail),
    .pending_o     (n_pending)
  );

  // --------------------------------------------------------------------------
  // Result side: ready stalls in random bursts, driven at negedge.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        res_if.ready = 1'b0;
        hold--;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        res_if.ready = 1'b0;
        hold = $urandom_range(0, 5);  // further stalled cycles after this one
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic cfg_t make_cfg(input logic [7:0] tc, input logic [7:0] td,
                                    input logic [7:0] cut, input logic [7:0] lo,
                                    input logic [7:0] cl, input logic [7:0] ch);
    cfg_t c;
    c.temp_low_charging    = tc;
    c.temp_low_discharging = td;
    c.volt_cutoff          = cut;
    c.volt_low             = lo;
    c.charge_level_low     = cl;
    c.charge_level_high    = ch;
    return c;
  endfunction

  // Random thresholds; overlap puts charge_level_low above charge_level_high
  function automatic cfg_t rand_cfg(input bit overlap);
    cfg_t c;
    c = make_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd0);
    if (overlap) begin
      c.charge_level_high = 8'($urandom_range(0, 127));
      c.charge_level_low  = 8'($urandom_range(128, 255));
    end else begin
      c.charge_level_low  = 8'($urandom_range(0, 127));
      c.charge_level_high = 8'($urandom_range(128, 255));
    end
    return c;
  endfunction

  // Half the samples land within +/-2 of some threshold, the rest are
  // uniform or at the rails.
  function automatic logic [7:0] pick_sample();
    int          v;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 255);
      1: v = $urandom_range(0, 1) ? 255 : 0;
      default: begin
        k = $urandom_range(0, 5);
        v = int'(cfg_shadow[8*k +: 8]) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return v[7:0];
  endfunction

  // One register write; write enable stays up for back-to-back writes and
  // is dropped by the caller.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(posedge clk);
  endtask

  // Full threshold set plus one dropped write to a spare index. Only called
  // with nothing in flight.
  task automatic load_cfg(input cfg_t c);
    write_reg(CFG_TEMP_LOW_CHG, c.temp_low_charging);
    write_reg(CFG_TEMP_LOW_DIS, c.temp_low_discharging);
    write_reg(CFG_VOLT_CUTOFF,  c.volt_cutoff);
    write_reg(CFG_VOLT_LOW,     c.volt_low);
    write_reg(CFG_CHARGE_LOW,   c.charge_level_low);
    write_reg(CFG_CHARGE_HIGH,  c.charge_level_high);
    write_reg($urandom_range(0, 1) ? CfgSpareIdxA : CfgSpareIdxB, 8'($urandom));
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = 8'($urandom);
    cfg_shadow = c;
  endtask

  // Send one request, with an optional random gap first. Valid stays high
  // after acceptance; the next call (or drain_requests) decides what follows.
  task automatic send_req(input cmd_e cmd, input logic [7:0] s, input logic pin);
    int unsigned gap;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid     = 1'b0;
        req_if.command   = 2'($urandom);
        req_if.sample    = 8'($urandom);
        req_if.pin_level = 1'($urandom);
      end
    end
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.command   = cmd;
    req_if.sample    = s;
    req_if.pin_level = pin;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // ext_ok=0 keeps the external-power flag clear and the charger untouched,
  // so the voltage events stay reachable.
  task automatic send_random(input bit ext_ok);
    int unsigned r;
    cmd_e        cmd;
    logic        pin;
    r = $urandom_range(0, 99);
    if (r < 25) cmd = CMD_VOLTAGE;
    else if (r < 50) cmd = CMD_TEMP;
    else if (r < 85 && ext_ok) cmd = CMD_CHARGER;
    else cmd = CMD_USB_PIN;
    pin = 1'($urandom);
    if (cmd == CMD_USB_PIN && !ext_ok) pin = 1'b0;
    send_req(cmd, pick_sample(), pin);
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic drain_requests();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n_items, input bit ext_ok, input bit idle_ok);
    for (int unsigned i = 0; i < n_items; i++) begin
      // re-roll idle rates every 25 requests so some stretches run flat out
      if (i % 25 == 0) begin
        send_gap_pct   = (idle_ok && $urandom_range(0, 2) != 0) ? 25 : 0;
        sink_stall_pct = (idle_ok && $urandom_range(0, 2) != 0) ? 20 : 0;
      end
      if (idle_ok && $urandom_range(0, 99) < 2) drain_requests();
      send_random(ext_ok);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cfg_t cfg_a;

    req_if.valid     = 1'b0;
    req_if.command   = CMD_VOLTAGE;
    req_if.sample    = '0;
    req_if.pin_level = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_TEMP_LOW_CHG;
    cfg_data         = '0;
    send_gap_pct     = 20;
    sink_stall_pct   = 20;
    cfg_shadow       = make_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, ChargeHighRst);

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset thresholds: nothing fires; a charger sample at the low level
    // without external power leaves the state unknown.
    send_req(CMD_VOLTAGE, 8'd0, 1'b1);
    send_req(CMD_CHARGER, 8'd0, 1'b1);

    // Directed set A, still on battery
    cfg_a = make_cfg(8'd100, 8'd50, 8'd40, 8'd80, 8'd60, 8'd200);
    drain_requests();
    load_cfg(cfg_a);
    send_req(CMD_VOLTAGE, 8'd39, 1'b0);   // below cutoff: power off
    send_req(CMD_VOLTAGE, 8'd40, 1'b1);   // cutoff reached: low battery
    send_req(CMD_VOLTAGE, 8'd79, 1'b0);
    send_req(CMD_VOLTAGE, 8'd80, 1'b0);   // at low threshold: none
    send_req(CMD_VOLTAGE, 8'd255, 1'b1);
    send_req(CMD_VOLTAGE, 8'd0, 1'b0);
    send_req(CMD_TEMP, 8'd49, 1'b0);      // unknown uses discharging limit
    send_req(CMD_TEMP, 8'd50, 1'b1);
    send_req(CMD_CHARGER, 8'd60, 1'b0);   // low level, no power: ignored
    send_req(CMD_USB_PIN, 8'd255, 1'b0);  // low pin changes nothing

    // Random on battery: voltage/temperature events, charger left alone
    drain_requests();
    load_cfg(rand_cfg(1'b0));
    run_phase(50, 1'b0, 1'b1);
    drain_requests();
    load_cfg(make_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(0, 127)),
                      8'($urandom_range(128, 255)), 8'd60, 8'd200));
    run_phase(50, 1'b0, 1'b1);

    // Directed set B: external power, charge cycle from unknown state
    drain_requests();
    load_cfg(cfg_a);
    send_req(CMD_USB_PIN, 8'd0, 1'b1);    // external power latched
    send_req(CMD_CHARGER, 8'd255, 1'b0);  // full from unknown
    send_req(CMD_VOLTAGE, 8'd0, 1'b0);    // on external power: no voltage event
    send_req(CMD_CHARGER, 8'd60, 1'b1);   // charging started
    send_req(CMD_CHARGER, 8'd0, 1'b0);    // already charging: none
    send_req(CMD_TEMP, 8'd99, 1'b0);      // charging limit applies
    send_req(CMD_TEMP, 8'd100, 1'b1);
    send_req(CMD_CHARGER, 8'd100, 1'b0);  // between levels: stopped
    send_req(CMD_CHARGER, 8'd100, 1'b1);  // already not charging: none
    send_req(CMD_CHARGER, 8'd60, 1'b0);
    send_req(CMD_CHARGER, 8'd200, 1'b0);  // full
    send_req(CMD_CHARGER, 8'd255, 1'b1);  // already not charging: none
    send_req(CMD_TEMP, 8'd49, 1'b0);      // back on discharging limit

    // Random phases over several threshold settings
    drain_requests();
    load_cfg(rand_cfg(1'b0));
    run_phase(100, 1'b1, 1'b1);

    drain_requests();
    load_cfg(make_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    run_phase(100, 1'b1, 1'b1);

    drain_requests();
    load_cfg(make_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    run_phase(100, 1'b1, 1'b1);

    // overlapping charger levels: the low test wins
    drain_requests();
    load_cfg(rand_cfg(1'b1));
    run_phase(100, 1'b1, 1'b1);

    // closing stretch with no idling on either side
    drain_requests();
    load_cfg(rand_cfg(1'b0));
    run_phase(100, 1'b1, 1'b0);

    drain_requests();
    // let any stray result show up before the verdict
    repeat (8) @(negedge clk);
    if (n_fail == 0) begin
      $display("[battery_charge_monitor] OK");
    end else begin
      $display("[battery_charge_monitor] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RunLimitNs);
    $display("[battery_charge_monitor] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bcm_pkg.sv
rtl/bcm_req_if.sv
rtl/bcm_res_if.sv
rtl/bcm_cfg_regs.sv
rtl/bcm_eval.sv
rtl/battery_charge_monitor.sv
sim/bcm_event_checker.sv
sim/battery_charge_monitor_tb.sv
